// ===== src/fbf_pkg.sv =====
// Package for the framed byte FIFO: depths, widths, operation codes and
// the request and response transaction structs.
// No dependencies.
package fbf_pkg;

   localparam int BYTE_DEPTH    = 1024;
   localparam int FRAME_DEPTH   = 32;
   localparam int BYTE_PTR_W    = $clog2(BYTE_DEPTH);
   localparam int FRAME_PTR_W   = $clog2(FRAME_DEPTH);
   localparam int COUNT_W       = 11;
   localparam int BYTES_HELD_W  = 11;
   localparam int FRAMES_HELD_W = 6;

   localparam logic [BYTE_PTR_W-1:0]  BYTE_LAST  = BYTE_PTR_W'(BYTE_DEPTH - 1);
   localparam logic [FRAME_PTR_W-1:0] FRAME_LAST = FRAME_PTR_W'(FRAME_DEPTH - 1);
   localparam logic [COUNT_W-1:0]     COUNT_MAX  = {COUNT_W{1'b1}};

   typedef enum logic [1:0] {
      FUNC_PUSH  = 2'd0,
      FUNC_POP   = 2'd1,
      FUNC_CLOSE = 2'd2
   } func_type;

   typedef struct packed {
      func_type   func;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]               read_byte;
      logic                     read_valid;
      logic                     frame_end;
      logic                     accepted;
      logic [BYTES_HELD_W-1:0]  bytes_held;
      logic [FRAMES_HELD_W-1:0] frames_held;
      logic                     bytes_full;
      logic                     bytes_empty;
      logic                     frames_full;
      logic                     frames_empty;
   } rsp_type;

endpackage

// ===== src/framed_byte_fifo.sv =====
// Framed byte FIFO top level: byte ring memory, frame length table, pointers
// and flags. Depends on fbf_pkg.
//
//   channel  | ports                          | transfer
//   ---------+--------------------------------+----------------------------------
//   request  | start, busy, req_payload       | start high and busy low at a rising edge
//   response | rsp_strobe, rsp_payload        | one-cycle strobe per transaction, no stall
//
// One transaction per clock; busy stays low. The response appears in the
// cycle after acceptance, a latency set by the registered read port of the
// byte memory. Reset clears pointers, flags and the open frame count; the byte
// memory and the closed frame table need no clearing since they are always
// written before read. The receiver cannot stall, so nothing backs up.
module framed_byte_fifo (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  fbf_pkg::req_type req_payload,
   output logic            rsp_strobe,
   output fbf_pkg::rsp_type rsp_payload
);
   import fbf_pkg::*;

   // Byte ring storage and its registered read data.
   logic [7:0] byte_mem [BYTE_DEPTH];
   logic [7:0] rd_byte_ff;

   // Counts of closed frames. The open frame's count lives in open_cnt_ff,
   // so the table is read only at the head slot.
   logic [COUNT_W-1:0] frame_cnt_ff [FRAME_DEPTH];
   logic [COUNT_W-1:0] open_cnt_ff, open_cnt_in;

   logic [BYTE_PTR_W-1:0]  byte_wr_ptr_ff, byte_wr_ptr_in;
   logic [BYTE_PTR_W-1:0]  byte_rd_ptr_ff, byte_rd_ptr_in;
   logic [FRAME_PTR_W-1:0] frame_wr_ptr_ff, frame_wr_ptr_in;
   logic [FRAME_PTR_W-1:0] frame_rd_ptr_ff, frame_rd_ptr_in;
   logic byte_full_ff, byte_full_in, byte_empty_ff, byte_empty_in;
   logic frame_full_ff, frame_full_in, frame_empty_ff, frame_empty_in;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_strobe_ff;

   logic                   accept;
   logic                   push_do, pop_do;
   logic                   cnt_we;
   logic [FRAME_PTR_W-1:0] cnt_waddr;
   logic [COUNT_W-1:0]     cnt_wdata;
   logic [COUNT_W-1:0]     head_cnt, head_cnt_dec;
   logic [BYTE_PTR_W-1:0]  byte_wr_next, byte_rd_next;
   logic [FRAME_PTR_W-1:0] frame_wr_next, frame_rd_next;

   // Every cycle can take a transaction.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Wrap pointers at the ring depth, which need not be a power of two.
   assign byte_wr_next  = (byte_wr_ptr_ff == BYTE_LAST) ? '0 : byte_wr_ptr_ff + 1'b1;
   assign byte_rd_next  = (byte_rd_ptr_ff == BYTE_LAST) ? '0 : byte_rd_ptr_ff + 1'b1;
   assign frame_wr_next = (frame_wr_ptr_ff == FRAME_LAST) ? '0 : frame_wr_ptr_ff + 1'b1;
   assign frame_rd_next = (frame_rd_ptr_ff == FRAME_LAST) ? '0 : frame_rd_ptr_ff + 1'b1;

   // With no closed frame pending the head slot is the open frame.
   assign head_cnt     = frame_empty_ff ? open_cnt_ff : frame_cnt_ff[frame_rd_ptr_ff];
   assign head_cnt_dec = (head_cnt != '0) ? head_cnt - 1'b1 : '0;

   always_comb begin
      byte_wr_ptr_in  = byte_wr_ptr_ff;
      byte_rd_ptr_in  = byte_rd_ptr_ff;
      frame_wr_ptr_in = frame_wr_ptr_ff;
      frame_rd_ptr_in = frame_rd_ptr_ff;
      byte_full_in    = byte_full_ff;
      byte_empty_in   = byte_empty_ff;
      frame_full_in   = frame_full_ff;
      frame_empty_in  = frame_empty_ff;
      open_cnt_in     = open_cnt_ff;
      push_do         = 1'b0;
      pop_do          = 1'b0;
      cnt_we          = 1'b0;
      cnt_waddr       = frame_rd_ptr_ff;
      cnt_wdata       = head_cnt_dec;
      rsp_in          = '0;

      if (accept) begin
         case (req_payload.func)
            FUNC_PUSH: begin
               // Refuse when either ring is full.
               if (!byte_full_ff && !frame_full_ff) begin
                  push_do         = 1'b1;
                  open_cnt_in     = (open_cnt_ff != COUNT_MAX) ?
                                    open_cnt_ff + 1'b1 : open_cnt_ff;
                  byte_wr_ptr_in  = byte_wr_next;
                  byte_empty_in   = 1'b0;
                  byte_full_in    = (byte_wr_next == byte_rd_ptr_ff);
                  rsp_in.accepted = 1'b1;
               end
            end
            FUNC_POP: begin
               if (!byte_empty_ff) begin
                  pop_do            = 1'b1;
                  rsp_in.read_valid = 1'b1;
                  rsp_in.accepted   = 1'b1;
                  if (frame_empty_ff) begin
                     open_cnt_in = head_cnt_dec;
                  end else begin
                     cnt_we = 1'b1;
                  end
                  byte_rd_ptr_in = byte_rd_next;
                  byte_full_in   = 1'b0;
                  byte_empty_in  = (byte_rd_next == byte_wr_ptr_ff);
                  // Advance the head once its last byte leaves.
                  if (head_cnt_dec == '0 && !frame_empty_ff) begin
                     rsp_in.frame_end = 1'b1;
                     frame_rd_ptr_in  = frame_rd_next;
                     frame_full_in    = 1'b0;
                     frame_empty_in   = (frame_rd_next == frame_wr_ptr_ff);
                  end
               end
            end
            FUNC_CLOSE: begin
               // Drop a close of an empty frame.
               if (!frame_full_ff && open_cnt_ff != '0) begin
                  cnt_we          = 1'b1;
                  cnt_waddr       = frame_wr_ptr_ff;
                  cnt_wdata       = open_cnt_ff;
                  open_cnt_in     = '0;
                  frame_wr_ptr_in = frame_wr_next;
                  frame_empty_in  = 1'b0;
                  frame_full_in   = (frame_wr_next == frame_rd_ptr_ff);
                  rsp_in.accepted = 1'b1;
               end
            end
            default: begin
               // Unused code: report status only.
            end
         endcase
      end

      // Occupancy after the operation.
      if (byte_full_in) begin
         rsp_in.bytes_held = BYTES_HELD_W'(BYTE_DEPTH);
      end else if (byte_wr_ptr_in >= byte_rd_ptr_in) begin
         rsp_in.bytes_held = BYTES_HELD_W'(byte_wr_ptr_in) - BYTES_HELD_W'(byte_rd_ptr_in);
      end else begin
         rsp_in.bytes_held = BYTES_HELD_W'(byte_wr_ptr_in) + BYTES_HELD_W'(BYTE_DEPTH)
                             - BYTES_HELD_W'(byte_rd_ptr_in);
      end
      if (frame_full_in) begin
         rsp_in.frames_held = FRAMES_HELD_W'(FRAME_DEPTH);
      end else if (frame_wr_ptr_in >= frame_rd_ptr_in) begin
         rsp_in.frames_held = FRAMES_HELD_W'(frame_wr_ptr_in)
                              - FRAMES_HELD_W'(frame_rd_ptr_in);
      end else begin
         rsp_in.frames_held = FRAMES_HELD_W'(frame_wr_ptr_in) + FRAMES_HELD_W'(FRAME_DEPTH)
                              - FRAMES_HELD_W'(frame_rd_ptr_in);
      end
      rsp_in.bytes_full   = byte_full_in;
      rsp_in.bytes_empty  = byte_empty_in;
      rsp_in.frames_full  = frame_full_in;
      rsp_in.frames_empty = frame_empty_in;
   end

   // Byte memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (push_do) begin
         byte_mem[byte_wr_ptr_ff] <= req_payload.data_byte;
      end
      if (pop_do) begin
         rd_byte_ff <= byte_mem[byte_rd_ptr_ff];
      end
   end

   // Frame count table; a slot is always written on close before it is read.
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         frame_cnt_ff[cnt_waddr] <= cnt_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_wr_ptr_ff  <= '0;
         byte_rd_ptr_ff  <= '0;
         frame_wr_ptr_ff <= '0;
         frame_rd_ptr_ff <= '0;
         byte_full_ff    <= 1'b0;
         byte_empty_ff   <= 1'b1;
         frame_full_ff   <= 1'b0;
         frame_empty_ff  <= 1'b1;
         open_cnt_ff     <= '0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         byte_wr_ptr_ff  <= byte_wr_ptr_in;
         byte_rd_ptr_ff  <= byte_rd_ptr_in;
         frame_wr_ptr_ff <= frame_wr_ptr_in;
         frame_rd_ptr_ff <= frame_rd_ptr_in;
         byte_full_ff    <= byte_full_in;
         byte_empty_ff   <= byte_empty_in;
         frame_full_ff   <= frame_full_in;
         frame_empty_ff  <= frame_empty_in;
         open_cnt_ff     <= open_cnt_in;
         rsp_strobe_ff   <= accept;
      end
   end

   // Hold the response fields for the strobe cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   // Merge in the memory read data; zero when no byte was popped.
   always_comb begin
      rsp_payload           = rsp_ff;
      rsp_payload.read_byte = rsp_ff.read_valid ? rd_byte_ff : 8'h00;
   end
   assign rsp_strobe = rsp_strobe_ff;

`ifndef SYNTH
   a_byte_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(byte_full_ff && byte_empty_ff))
      else $error("byte ring flagged full and empty at once");

   a_byte_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      byte_empty_ff |-> (byte_wr_ptr_ff == byte_rd_ptr_ff))
      else $error("byte ring empty with unequal pointers");

   a_frame_full_ptrs: assert property (@(posedge clock) disable iff (reset)
      frame_full_ff |-> (frame_wr_ptr_ff == frame_rd_ptr_ff))
      else $error("frame ring full with unequal pointers");

   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted transaction produced no response");

   a_frame_end_on_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.frame_end) |-> $past(frame_rd_ptr_ff) != frame_rd_ptr_ff
         || $past(frame_full_ff))
      else $error("frame end reported without head advance");
`endif

endmodule

// ===== tb/sv/fbf_checker.sv =====
// Response checker for the framed byte FIFO: predicts each transaction's
// response from its own ring and frame table, then compares field by field.
// Depends on fbf_pkg.
module fbf_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  fbf_pkg::req_type req_payload,
   input  logic             rsp_strobe,
   input  fbf_pkg::rsp_type rsp_payload,
   output int               error_count,
   output int               pending_count
);
   import fbf_pkg::*;

   // Shadow copy of the FIFO state.
   logic [7:0]             ring_data [BYTE_DEPTH];
   logic [COUNT_W-1:0]     frame_len [FRAME_DEPTH];
   logic [BYTE_PTR_W-1:0]  wr_byte, rd_byte;
   logic [FRAME_PTR_W-1:0] wr_frame, rd_frame;
   logic                   ring_full, ring_empty, frm_full, frm_empty;

   rsp_type predicted_rsp_q [$];
   rsp_type oldest_rsp;
   int      mismatches = 0;

   assign error_count = mismatches;

   function automatic void clear_fifo_state();
      for (int i = 0; i < FRAME_DEPTH; i++) frame_len[i] = '0;
      wr_byte    = '0;
      rd_byte    = '0;
      wr_frame   = '0;
      rd_frame   = '0;
      ring_full  = 1'b0;
      ring_empty = 1'b1;
      frm_full   = 1'b0;
      frm_empty  = 1'b1;
   endfunction

   // Apply one operation to the shadow state and return the response it earns.
   function automatic rsp_type apply_fifo_op(input req_type op);
      rsp_type res;
      int      nbytes, nframes;
      res = '0;
      case (op.func)
         FUNC_PUSH: begin
            if (!ring_full && !frm_full) begin
               ring_data[wr_byte] = op.data_byte;
               if (frame_len[wr_frame] != COUNT_MAX) frame_len[wr_frame]++;
               wr_byte    = (wr_byte == BYTE_LAST) ? '0 : wr_byte + 1'b1;
               ring_empty = 1'b0;
               if (wr_byte == rd_byte) ring_full = 1'b1;
               res.accepted = 1'b1;
            end
         end
         FUNC_POP: begin
            if (!ring_empty) begin
               res.read_byte  = ring_data[rd_byte];
               res.read_valid = 1'b1;
               res.accepted   = 1'b1;
               if (frame_len[rd_frame] != '0) frame_len[rd_frame]--;
               rd_byte   = (rd_byte == BYTE_LAST) ? '0 : rd_byte + 1'b1;
               ring_full = 1'b0;
               if (rd_byte == wr_byte) ring_empty = 1'b1;
               // Retire the head frame once its last byte is gone.
               if (frame_len[rd_frame] == '0 && !frm_empty) begin
                  res.frame_end = 1'b1;
                  rd_frame = (rd_frame == FRAME_LAST) ? '0 : rd_frame + 1'b1;
                  frm_full = 1'b0;
                  if (rd_frame == wr_frame) frm_empty = 1'b1;
               end
            end
         end
         FUNC_CLOSE: begin
            if (!frm_full && frame_len[wr_frame] != '0) begin
               wr_frame  = (wr_frame == FRAME_LAST) ? '0 : wr_frame + 1'b1;
               frm_empty = 1'b0;
               if (wr_frame == rd_frame) frm_full = 1'b1;
               res.accepted = 1'b1;
            end
         end
         default: ;
      endcase
      nbytes  = ring_full ? BYTE_DEPTH :
                (wr_byte >= rd_byte) ? int'(wr_byte) - int'(rd_byte)
                                     : int'(wr_byte) + BYTE_DEPTH - int'(rd_byte);
      nframes = frm_full ? FRAME_DEPTH :
                (wr_frame >= rd_frame) ? int'(wr_frame) - int'(rd_frame)
                                       : int'(wr_frame) + FRAME_DEPTH - int'(rd_frame);
      res.bytes_held   = BYTES_HELD_W'(nbytes);
      res.frames_held  = FRAMES_HELD_W'(nframes);
      res.bytes_full   = ring_full;
      res.bytes_empty  = ring_empty;
      res.frames_full  = frm_full;
      res.frames_empty = frm_empty;
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // Take the request first so a same-edge response still finds its entry.
   always @(posedge clock) begin
      if (reset) begin
         clear_fifo_state();
         predicted_rsp_q.delete();
         pending_count <= 0;
      end else begin
         if (start === 1'b1 && busy === 1'b0)
            predicted_rsp_q.push_back(apply_fifo_op(req_payload));
         if (rsp_strobe === 1'b1) begin
            if (predicted_rsp_q.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response, expected none, actual %h",
                        $time, rsp_payload);
            end else begin
               oldest_rsp = predicted_rsp_q.pop_front();
               compare_field("read_byte", 16'(oldest_rsp.read_byte),
                             16'(rsp_payload.read_byte));
               compare_field("read_valid", 16'(oldest_rsp.read_valid),
                             16'(rsp_payload.read_valid));
               compare_field("frame_end", 16'(oldest_rsp.frame_end),
                             16'(rsp_payload.frame_end));
               compare_field("accepted", 16'(oldest_rsp.accepted),
                             16'(rsp_payload.accepted));
               compare_field("bytes_held", 16'(oldest_rsp.bytes_held),
                             16'(rsp_payload.bytes_held));
               compare_field("frames_held", 16'(oldest_rsp.frames_held),
                             16'(rsp_payload.frames_held));
               compare_field("bytes_full", 16'(oldest_rsp.bytes_full),
                             16'(rsp_payload.bytes_full));
               compare_field("bytes_empty", 16'(oldest_rsp.bytes_empty),
                             16'(rsp_payload.bytes_empty));
               compare_field("frames_full", 16'(oldest_rsp.frames_full),
                             16'(rsp_payload.frames_full));
               compare_field("frames_empty", 16'(oldest_rsp.frames_empty),
                             16'(rsp_payload.frames_empty));
            end
         end
         pending_count <= predicted_rsp_q.size();
      end
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the framed byte FIFO testbench: clock, reset, stimulus and verdict.
// Depends on fbf_pkg, framed_byte_fifo and fbf_checker.
module tb_top;
   import fbf_pkg::*;

   // The two-bit operation field leaves one code with no meaning; drive it
   // to confirm the block treats it as a no-op that still reports status.
   localparam func_type FUNC_UNUSED = func_type'(2'd3);
   localparam int       CYCLE_LIMIT = 400_000;
   localparam int       RANDOM_OPS  = 950;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;
   int      error_count;
   int      pending_count;
   int      cycle_count = 0;
   bit      steady_flow;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   framed_byte_fifo DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   fbf_checker fifo_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_payload   (req_payload),
      .rsp_strobe    (rsp_strobe),
      .rsp_payload   (rsp_payload),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Idle gap before a transaction: mostly none, some short, a few long.
   // Skip gaps entirely while a steady-flow stretch is running.
   function automatic int next_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_flow || roll < 70) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Drive one transaction and hold it until the block takes it. Leave start
   // high on return so back-to-back transactions need no extra edge.
   task automatic send_op(input func_type op, input logic [7:0] value);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= '{func: op, data_byte: value};
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   initial begin
      int kind, len, random_ops;
      start       = 1'b0;
      req_payload = '0;
      reset       = 1'b1;
      steady_flow = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: refusals on an empty FIFO, extreme bytes, a closed frame
      // followed by an open one, and draining both.
      send_op(FUNC_POP, 8'h00);      // pop from empty ring
      send_op(FUNC_CLOSE, 8'h00);    // close with nothing written
      send_op(FUNC_UNUSED, 8'hFF);
      send_op(FUNC_PUSH, 8'h00);
      send_op(FUNC_PUSH, 8'hFF);
      send_op(FUNC_PUSH, 8'hA5);
      send_op(FUNC_CLOSE, 8'h00);
      send_op(FUNC_CLOSE, 8'h00);    // new open frame is empty, so ignored
      send_op(FUNC_PUSH, 8'h5A);     // stays in the open frame
      send_op(FUNC_UNUSED, 8'h00);
      send_op(FUNC_POP, 8'h00);
      send_op(FUNC_POP, 8'h00);
      send_op(FUNC_POP, 8'h00);      // last byte of the closed frame
      send_op(FUNC_POP, 8'h00);      // pop from the open frame
      send_op(FUNC_POP, 8'h00);      // empty again
      send_op(FUNC_CLOSE, 8'h00);

      // Fill the frame table: one byte per frame until both push and close
      // are refused, then drain past empty.
      for (int i = 0; i < FRAME_DEPTH + 1; i++) begin
         send_op(FUNC_PUSH, any_byte());
         send_op(FUNC_CLOSE, any_byte());
      end
      send_op(FUNC_PUSH, any_byte());
      for (int i = 0; i < FRAME_DEPTH + 2; i++) send_op(FUNC_POP, any_byte());

      // Fill the byte ring past full with 50-byte frames, close the partial
      // frame, then drain past empty.
      steady_flow = ($urandom_range(0, 1) == 0);
      for (int i = 0; i < BYTE_DEPTH + 6; i++) begin
         send_op(FUNC_PUSH, any_byte());
         if (i % 50 == 49) send_op(FUNC_CLOSE, any_byte());
      end
      send_op(FUNC_CLOSE, any_byte());
      for (int i = 0; i < BYTE_DEPTH + 6; i++) send_op(FUNC_POP, any_byte());

      // Random: mostly whole frames and drains, with some noise and broken
      // frames. Hold a no-idle stretch now and then.
      random_ops = 0;
      while (random_ops < RANDOM_OPS) begin
         steady_flow = ($urandom_range(0, 5) == 0);
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48)
                                              : $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 5) == 0) send_op(FUNC_POP, any_byte());
               else send_op(FUNC_PUSH, any_byte());
            end
            send_op(FUNC_CLOSE, any_byte());
            random_ops += len + 1;
         end else if (kind <= 7) begin
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) send_op(FUNC_POP, any_byte());
            random_ops += len;
         end else if (kind == 8) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
               send_op(func_type'($urandom_range(0, 3)), any_byte());
            random_ops += len;
         end else begin
            // Broken frame: double close, then a few bytes left open.
            send_op(FUNC_CLOSE, any_byte());
            send_op(FUNC_CLOSE, any_byte());
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) send_op(FUNC_PUSH, any_byte());
            random_ops += len + 2;
         end
      end

      // Drop start, wait out the outstanding responses, then keep running
      // to catch anything stray.
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/fbf_pkg.sv
src/framed_byte_fifo.sv
tb/sv/fbf_checker.sv
tb/sv/tb_top.sv
